### src/mpa_pkg.sv
`timescale 1ns / 1ps

package mpa_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int MAX_WINDOW   = 4;
	localparam int MAX_STEP     = 7;
	localparam int COL_W        = 10;
	localparam int ROW_W        = 10;
	localparam int DIM_W        = 11;
	localparam int KS_W         = 3;
	localparam int OFF_W        = 2;
	localparam int PIX_W        = 16;
	localparam int POS_W        = 20;
	localparam int ADDR_W       = 12;
	localparam int ENTRY_W      = PIX_W + POS_W;
	localparam int OUT_W        = 56;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd3;

	typedef struct packed {
		logic             ok;
		logic             emit;
		logic [COL_W-1:0] idx;
	} axis_t;

	// Window placement along one axis for a pixel at offset d inside the window.
	// p is the pixel coordinate, q and m are p / s and p % s.
	function automatic axis_t axis_calc(input logic [OFF_W-1:0] d, input logic [COL_W-1:0] p,
			input logic [KS_W-1:0] m, input logic [COL_W-1:0] q, input logic [KS_W-1:0] s,
			input logic [DIM_W-1:0] lim, input logic [KS_W-1:0] k);
		axis_t            res;
		logic [KS_W-1:0]  t;
		logic [KS_W-1:0]  t2;
		logic [KS_W-1:0]  quot;
		logic [11:0]      span;
		t = {1'b0, d};
		for (int n = 0; n < 3; n++) begin
			if (t >= s) t = t - s;
		end
		span = {2'b00, p} - {10'd0, d} + {9'd0, s};
		res.ok = ({1'b0, d} < k) && (p >= {8'd0, d}) && (t == m) && (span <= {1'b0, lim});
		t2 = {1'b0, d} - m;
		quot = (s == 3'd1) ? t2 : {2'b00, (t2 != 3'd0)};
		res.idx = q - {7'd0, quot};
		res.emit = ({1'b0, d} == k - 3'd1) || ({1'b0, p} == lim - 11'd1);
		return res;
	endfunction

endpackage

### src/max_pool_with_argmax.sv
`timescale 1ns / 1ps
// Each item is accepted in IDLE; SCAN then visits each window offset pair
// (window_size squared, up to 16) and UPD does one read-modify-write of the
// window store for each window the pixel lies in, waiting on output stalls.
// No new item is taken until the serial offset scan of the last one is done.
// Reset (asynchronous, active low) restores the register defaults and clears
// the counters; the window store is not cleared.
module max_pool_with_argmax (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mpa_pkg::PIX_W-1:0]          s_tdata,   // pixel_value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mpa_pkg::OUT_W-1:0]          m_tdata,   // max_value, arg_index, out_row, out_col
	output logic                               m_tlast,   // last_of_run
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpa_pkg::DIM_W-1:0]          cfg_data
);

	typedef enum logic [1:0] {IDLE, SCAN, UPD} state_t;

	state_t                       state_q;
	logic [mpa_pkg::DIM_W-1:0]    w_q, h_q;
	logic [mpa_pkg::KS_W-1:0]     k_q, s_q;
	logic [mpa_pkg::DIM_W-1:0]    w_eff, h_eff;
	logic [mpa_pkg::KS_W-1:0]     k_eff, s_eff;
	logic [mpa_pkg::COL_W-1:0]    c_q, cq_q, r_q, rq_q;
	logic [mpa_pkg::KS_W-1:0]     cm_q, rm_q;
	logic [mpa_pkg::POS_W-1:0]    pos_q;
	logic [mpa_pkg::PIX_W-1:0]    pix_q;
	logic [mpa_pkg::OFF_W-1:0]    dn_q, dm_q, last_dn, last_dm;
	mpa_pkg::axis_t               row_lane [4];
	mpa_pkg::axis_t               col_lane [4];
	mpa_pkg::axis_t               row_c, col_c;
	logic [mpa_pkg::ADDR_W-1:0]   addr_q, raddr;
	logic [mpa_pkg::ROW_W-1:0]    ci_q;
	logic [mpa_pkg::COL_W-1:0]    cj_q;
	logic                         emit_q, clast_q, first_q;
	logic                         we, can_go, take, done;
	logic [mpa_pkg::ENTRY_W-1:0]  rdata, wdata;
	logic                         ov_q, olast_q;
	logic [mpa_pkg::OUT_W-1:0]    odata_q;

	assign w_eff = (w_q == '0) ? 11'd1 : (w_q > 11'(mpa_pkg::MAX_WIDTH)) ?
		11'(mpa_pkg::MAX_WIDTH) : w_q;
	assign h_eff = (h_q == '0) ? 11'd1 : (h_q > 11'(mpa_pkg::MAX_HEIGHT)) ?
		11'(mpa_pkg::MAX_HEIGHT) : h_q;
	assign k_eff = (k_q == '0) ? 3'd1 : (k_q > 3'(mpa_pkg::MAX_WINDOW)) ?
		3'(mpa_pkg::MAX_WINDOW) : k_q;
	assign s_eff = (s_q == '0) ? 3'd1 : s_q;

	always_comb begin
		last_dn = '0;
		last_dm = '0;
		for (int n = 3; n >= 0; n--) begin
			row_lane[n] = mpa_pkg::axis_calc(2'(n), r_q, rm_q, rq_q, s_eff, h_eff, k_eff);
			col_lane[n] = mpa_pkg::axis_calc(2'(n), c_q, cm_q, cq_q, s_eff, w_eff, k_eff);
			if (row_lane[n].ok && row_lane[n].emit) last_dn = 2'(n);
			if (col_lane[n].ok && col_lane[n].emit) last_dm = 2'(n);
		end
		row_c = row_lane[dn_q];
		col_c = col_lane[dm_q];
	end

	assign raddr  = {row_c.idx[1:0], col_c.idx};
	assign can_go = !emit_q || !ov_q || m_tready;
	assign we     = (state_q == UPD) && can_go;
	assign take   = first_q || ($signed(pix_q) > $signed(rdata[mpa_pkg::ENTRY_W-1:mpa_pkg::POS_W]));
	assign wdata  = take ? {pix_q, pos_q} : rdata;
	assign done   = (dn_q == '0) && (dm_q == '0);

	mpa_ram #(.AW(mpa_pkg::ADDR_W), .DW(mpa_pkg::ENTRY_W)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign s_tready  = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = ov_q;
	assign m_tdata   = odata_q;
	assign m_tlast   = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			w_q <= 11'd416;
			h_q <= 11'd416;
			k_q <= 3'd2;
			s_q <= 3'd2;
			c_q <= '0; cq_q <= '0; cm_q <= '0;
			r_q <= '0; rq_q <= '0; rm_q <= '0;
			pos_q <= '0;
			dn_q <= '0;
			dm_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && m_tready && !(we && emit_q)) ov_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					mpa_pkg::REG_WIDTH:  w_q <= cfg_data;
					mpa_pkg::REG_HEIGHT: h_q <= cfg_data;
					mpa_pkg::REG_WINDOW: k_q <= cfg_data[mpa_pkg::KS_W-1:0];
					mpa_pkg::REG_STEP:   s_q <= cfg_data[mpa_pkg::KS_W-1:0];
					default: ;
				endcase
				c_q <= '0; cq_q <= '0; cm_q <= '0;
				r_q <= '0; rq_q <= '0; rm_q <= '0;
				pos_q <= '0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						pix_q   <= s_tdata;
						dn_q    <= 2'(k_eff - 3'd1);
						dm_q    <= 2'(k_eff - 3'd1);
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (row_c.ok && col_c.ok) begin
						addr_q  <= raddr;
						ci_q    <= row_c.idx;
						cj_q    <= col_c.idx;
						emit_q  <= row_c.emit && col_c.emit;
						clast_q <= (dn_q == last_dn) && (dm_q == last_dm);
						first_q <= done;
						state_q <= UPD;
					end else if (done) begin
						state_q <= IDLE;
					end else if (dm_q == '0) begin
						dn_q <= dn_q - 2'd1;
						dm_q <= 2'(k_eff - 3'd1);
					end else begin
						dm_q <= dm_q - 2'd1;
					end
				end
				UPD: begin
					if (can_go) begin
						if (emit_q) begin
							ov_q    <= 1'b1;
							olast_q <= clast_q;
							odata_q <= {cj_q, ci_q, wdata[mpa_pkg::POS_W-1:0],
								wdata[mpa_pkg::ENTRY_W-1:mpa_pkg::POS_W]};
						end
						if (done) begin
							state_q <= IDLE;
						end else begin
							state_q <= SCAN;
							if (dm_q == '0) begin
								dn_q <= dn_q - 2'd1;
								dm_q <= 2'(k_eff - 3'd1);
							end else begin
								dm_q <= dm_q - 2'd1;
							end
						end
					end
				end
				default: state_q <= IDLE;
			endcase
			if (state_q != IDLE && done && !cfg_valid &&
					((state_q == SCAN && !(row_c.ok && col_c.ok)) ||
					(state_q == UPD && can_go))) begin
				if ({1'b0, c_q} + 11'd1 >= w_eff) begin
					c_q <= '0; cq_q <= '0; cm_q <= '0;
					if ({1'b0, r_q} + 11'd1 >= h_eff) begin
						r_q <= '0; rq_q <= '0; rm_q <= '0;
						pos_q <= '0;
					end else begin
						r_q <= r_q + 10'd1;
						pos_q <= pos_q + 20'd1;
						if (rm_q + 3'd1 == s_eff) begin
							rm_q <= '0;
							rq_q <= rq_q + 10'd1;
						end else begin
							rm_q <= rm_q + 3'd1;
						end
					end
				end else begin
					c_q <= c_q + 10'd1;
					pos_q <= pos_q + 20'd1;
					if (cm_q + 3'd1 == s_eff) begin
						cm_q <= '0;
						cq_q <= cq_q + 10'd1;
					end else begin
						cm_q <= cm_q + 3'd1;
					end
				end
			end
		end
	end

	a_col_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, c_q} < w_eff) else $error("column counter outside plane");
	a_row_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, r_q} < h_eff) else $error("row counter outside plane");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cm_q < s_eff) && (rm_q < s_eff)) else $error("stride phase out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(we && emit_q) |-> (!ov_q || m_tready)) else $error("result overwritten");

endmodule

### src/mpa_ram.sv
`timescale 1ns / 1ps

module mpa_ram #(
	parameter int AW = 12,
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### sim/tb_max_pool_with_argmax.sv
`timescale 1ns / 1ps

module tb_max_pool_with_argmax;

	typedef struct {
		logic [mpa_pkg::PIX_W-1:0] max_value;
		logic [mpa_pkg::POS_W-1:0] arg_index;
		logic [9:0]                out_row;
		logic [9:0]                out_col;
		logic                      last_of_run;
	} pool_result_t;

	class pool_scoreboard;
		int unsigned      width_reg;
		int unsigned      height_reg;
		int unsigned      window_reg;
		int unsigned      step_reg;
		int unsigned      col;
		int unsigned      row;
		logic signed [15:0] win_max [4096];
		logic [mpa_pkg::POS_W-1:0] win_arg [4096];
		pool_result_t     pending_windows[$];
		int               errors;

		function new();
			width_reg = 416;
			height_reg = 416;
			window_reg = 2;
			step_reg = 2;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			if (v == 0) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void set_reg(logic [mpa_pkg::CFG_IDX_W-1:0] idx,
				logic [mpa_pkg::DIM_W-1:0] val);
			case (idx)
				mpa_pkg::REG_WIDTH: width_reg = 32'(val);
				mpa_pkg::REG_HEIGHT: height_reg = 32'(val);
				mpa_pkg::REG_WINDOW: window_reg = 32'(val[mpa_pkg::KS_W-1:0]);
				mpa_pkg::REG_STEP: step_reg = 32'(val[mpa_pkg::KS_W-1:0]);
				default: ;
			endcase
			col = 0;
			row = 0;
		endfunction

		function void note_pixel(logic signed [15:0] pix);
			int unsigned  w;
			int unsigned  h;
			int unsigned  k;
			int unsigned  s;
			int unsigned  i;
			int unsigned  j;
			int unsigned  a;
			int unsigned  last_r;
			int unsigned  last_c;
			int unsigned  n;
			logic [mpa_pkg::POS_W-1:0] pos;
			pool_result_t res;
			w = clip(width_reg, mpa_pkg::MAX_WIDTH);
			h = clip(height_reg, mpa_pkg::MAX_HEIGHT);
			k = clip(window_reg, mpa_pkg::MAX_WINDOW);
			s = clip(step_reg, mpa_pkg::MAX_STEP);
			pos = 20'(row * w + col);
			n = 0;
			for (int dn = k - 1; dn >= 0; dn--) begin
				if (row < dn || ((row - dn) % s) != 0) continue;
				i = (row - dn) / s;
				if (i >= h / s) continue;
				last_r = i * s + k - 1;
				if (last_r > h - 1) last_r = h - 1;
				for (int dm = k - 1; dm >= 0; dm--) begin
					if (col < dm || ((col - dm) % s) != 0) continue;
					j = (col - dm) / s;
					if (j >= w / s) continue;
					a = (i % mpa_pkg::MAX_WINDOW) * mpa_pkg::MAX_WIDTH + j;
					if ((dn == 0 && dm == 0) || pix > win_max[a]) begin
						win_max[a] = pix;
						win_arg[a] = pos;
					end
					last_c = j * s + k - 1;
					if (last_c > w - 1) last_c = w - 1;
					if (last_r == row && last_c == col && n < 16) begin
						if (n > 0) pending_windows[$].last_of_run = 1'b0;
						res.max_value = win_max[a];
						res.arg_index = win_arg[a];
						res.out_row = 10'(i);
						res.out_col = 10'(j);
						res.last_of_run = 1'b1;
						pending_windows.push_back(res);
						n++;
					end
				end
			end
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_window(logic [mpa_pkg::OUT_W-1:0] data, logic lst);
			pool_result_t e;
			if (pending_windows.size() == 0) begin
				$error("unexpected result %h", data);
				errors++;
				return;
			end
			e = pending_windows.pop_front();
			if (data[15:0] !== e.max_value) begin
				$error("max_value expected %h got %h", e.max_value, data[15:0]);
				errors++;
			end
			if (data[35:16] !== e.arg_index) begin
				$error("arg_index expected %0d got %0d", e.arg_index, data[35:16]);
				errors++;
			end
			if (data[45:36] !== e.out_row) begin
				$error("out_row expected %0d got %0d", e.out_row, data[45:36]);
				errors++;
			end
			if (data[55:46] !== e.out_col) begin
				$error("out_col expected %0d got %0d", e.out_col, data[55:46]);
				errors++;
			end
			if (lst !== e.last_of_run) begin
				$error("last_of_run expected %b got %b", e.last_of_run, lst);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [mpa_pkg::PIX_W-1:0]     s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [mpa_pkg::OUT_W-1:0]     m_tdata;
	logic                          m_tlast;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mpa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mpa_pkg::DIM_W-1:0]     cfg_data;

	pool_scoreboard sb;
	bit             steady;
	int             random_pixels;

	max_pool_with_argmax dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_window(m_tdata, m_tlast);
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (steady || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic wait_drained();
		while (sb.pending_windows.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [mpa_pkg::CFG_IDX_W-1:0] idx,
			logic [mpa_pkg::DIM_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_plane(int w, int h, int k, int s);
		s_tvalid <= 1'b0;
		wait_drained();
		write_reg(mpa_pkg::REG_WIDTH, 11'(w));
		write_reg(mpa_pkg::REG_HEIGHT, 11'(h));
		write_reg(mpa_pkg::REG_WINDOW, 11'(k));
		write_reg(mpa_pkg::REG_STEP, 11'(s));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [mpa_pkg::PIX_W-1:0] v);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tdata <= v;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(v);
	endtask

	function automatic logic [mpa_pkg::PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'(16'h0100 * $urandom_range(0, 2));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int w;
		int h;
		int cnt;
		sb = new();
		steady = 1'b0;
		random_pixels = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Overlapping windows with edge clipping, extreme values and ties.
		set_plane(5, 4, 3, 2);
		send_pixel(16'h8000);
		send_pixel(16'h7FFF);
		send_pixel(16'h7FFF);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		for (int n = 0; n < 15; n++) send_pixel(n[0] ? 16'h8000 : 16'h0001);
		// Zero registers act as one.
		set_plane(0, 0, 0, 0);
		repeat (3) send_pixel(pick_pixel());
		// Oversized width and window, single row.
		set_plane(2047, 1, 7, 1);
		repeat (3) send_pixel(pick_pixel());
		// Stride beyond the window leaves pixels uncovered.
		set_plane(7, 2047, 4, 7);
		repeat (3) send_pixel(pick_pixel());

		while (random_pixels < 140) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			set_plane(w, h, $urandom_range(0, 7), $urandom_range(0, 7));
			cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h) : w * h * $urandom_range(1, 2);
			if (cnt > 140 - random_pixels) cnt = 140 - random_pixels;
			if (random_pixels > 100) steady = 1'b1;
			for (int n = 0; n < cnt; n++) begin
				send_pixel(pick_pixel());
				random_pixels++;
			end
		end
		s_tvalid <= 1'b0;
		wait_drained();
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
